// File: sv/max_heap_priority_queue_top_defines.svh
// Assertion macros for the heap priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define HPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpq check failed: same-cycle implication");

`define HPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpq check failed: next-cycle implication");

`else

`define HPQ_ASSERT_IMP(lbl, ante, cons)

`define HPQ_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: sv/hpq_pkg.sv
`default_nettype none

package hpq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = CNT_W + 1;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int ENTRY_W  = 7;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef struct packed {
        logic                      action;
        logic signed [DATA_W-1:0]  value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  removed_value;
        logic signed [DATA_W-1:0]  top_value;
        logic [ENTRY_W-1:0]        entry_count;
    } rsp_t;

    // microprogram steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ROUTE,
        ST_INS,
        ST_UP_RD,
        ST_UP_CMP,
        ST_REM_RD,
        ST_REM_LD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_PLACE,
        ST_TOP_RD,
        ST_EMIT
    } step_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_FAIL,
        C_REMOVE,
        C_AT_ROOT,
        C_PARENT_GE,
        C_NO_LEFT,
        C_STAY,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PARENT,
        RD_ROOT_LAST,
        RD_CHILDREN,
        RD_ROOT
    } rd_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CUR,
        WR_PARENT,
        WR_CHILD
    } wr_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_NEW,
        POS_ONE,
        POS_PARENT,
        POS_CHILD
    } pos_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // datapath actions of one step
    typedef struct packed {
        logic    take;
        logic    judge;
        logic    load_rem;
        logic    emit;
        rd_t     rd;
        wr_t     wr;
        pos_op_t pos;
        cnt_op_t cnt;
    } ctl_t;

    // one control word: jump on cond, actions optionally only on fall-through
    typedef struct packed {
        cond_t cond;
        step_t jt;
        step_t jf;
        logic  gate;
        ctl_t  ctl;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic fail;
        logic remove;
        logic at_root;
        logic parent_ge;
        logic no_left;
        logic stay;
        logic out_busy;
    } flags_t;

    localparam ctl_t CTL_NOP = '{take: 1'b0, judge: 1'b0, load_rem: 1'b0, emit: 1'b0,
                                 rd: RD_NONE, wr: WR_NONE, pos: POS_HOLD,
                                 cnt: CNT_HOLD};

    function automatic ucode_t ucode(step_t s);
        ucode_t w;
        w = '{cond: C_ALWAYS, jt: ST_IDLE, jf: ST_IDLE, gate: 1'b0, ctl: CTL_NOP};
        case (s)
            ST_IDLE: begin
                w.cond = C_ACCEPT;  w.jt = ST_DISPATCH; w.jf = ST_IDLE;
                w.ctl.take = 1'b1;
            end
            ST_DISPATCH: begin
                w.cond = C_FAIL;    w.jt = ST_TOP_RD;   w.jf = ST_ROUTE;
                w.ctl.judge = 1'b1;
            end
            ST_ROUTE: begin
                w.cond = C_REMOVE;  w.jt = ST_REM_RD;   w.jf = ST_INS;
            end
            ST_INS: begin
                w.jt = ST_UP_RD;
                w.ctl.cnt = CNT_INC;
                w.ctl.pos = POS_NEW;
            end
            ST_UP_RD: begin
                w.cond = C_AT_ROOT; w.jt = ST_PLACE;    w.jf = ST_UP_CMP;
                w.ctl.rd = RD_PARENT;
            end
            ST_UP_CMP: begin
                w.cond = C_PARENT_GE; w.jt = ST_PLACE;  w.jf = ST_UP_RD;
                w.gate = 1'b1;
                w.ctl.wr  = WR_PARENT;
                w.ctl.pos = POS_PARENT;
            end
            ST_REM_RD: begin
                w.jt = ST_REM_LD;
                w.ctl.rd = RD_ROOT_LAST;
            end
            ST_REM_LD: begin
                w.jt = ST_DN_RD;
                w.ctl.load_rem = 1'b1;
                w.ctl.cnt = CNT_DEC;
                w.ctl.pos = POS_ONE;
            end
            ST_DN_RD: begin
                w.cond = C_NO_LEFT; w.jt = ST_PLACE;    w.jf = ST_DN_CMP;
                w.ctl.rd = RD_CHILDREN;
            end
            ST_DN_CMP: begin
                w.cond = C_STAY;    w.jt = ST_PLACE;    w.jf = ST_DN_RD;
                w.gate = 1'b1;
                w.ctl.wr  = WR_CHILD;
                w.ctl.pos = POS_CHILD;
            end
            ST_PLACE: begin
                w.jt = ST_TOP_RD;
                w.ctl.wr = WR_CUR;
            end
            ST_TOP_RD: begin
                w.jt = ST_EMIT;
                w.ctl.rd = RD_ROOT;
            end
            ST_EMIT: begin
                w.cond = C_OUT_BUSY; w.jt = ST_EMIT;    w.jf = ST_IDLE;
                w.gate = 1'b1;
                w.ctl.emit = 1'b1;
            end
            default: begin
                w.jt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // heap index (1-based) to store address
    function automatic logic [ADDR_W-1:0] addr_of(logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] a;
        a = idx - IDX_W'(1);
        return a[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/hpq_sequencer.sv
`default_nettype none

module hpq_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hpq_pkg::flags_t flags,
    output hpq_pkg::ctl_t        ctl,
    output logic                 idle
);

    hpq_pkg::step_t  upc_reg;
    hpq_pkg::step_t  upc_next;
    hpq_pkg::ucode_t word;
    logic            hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= hpq_pkg::ST_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_comb
    begin
        word = hpq_pkg::ucode(upc_reg);
        unique case (word.cond)
            hpq_pkg::C_ALWAYS:    hit = 1'b1;
            hpq_pkg::C_ACCEPT:    hit = flags.accept;
            hpq_pkg::C_FAIL:      hit = flags.fail;
            hpq_pkg::C_REMOVE:    hit = flags.remove;
            hpq_pkg::C_AT_ROOT:   hit = flags.at_root;
            hpq_pkg::C_PARENT_GE: hit = flags.parent_ge;
            hpq_pkg::C_NO_LEFT:   hit = flags.no_left;
            hpq_pkg::C_STAY:      hit = flags.stay;
            hpq_pkg::C_OUT_BUSY:  hit = flags.out_busy;
            default:              hit = 1'b1;
        endcase
        upc_next = hit ? word.jt : word.jf;
        // gated steps act only when they fall through
        ctl  = (word.gate && hit) ? hpq_pkg::CTL_NOP : word.ctl;
        idle = (upc_reg == hpq_pkg::ST_IDLE);
    end

endmodule

`default_nettype wire

// File: sv/hpq_datapath.sv
`default_nettype none

`include "max_heap_priority_queue_top_defines.svh"

module hpq_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hpq_pkg::ctl_t ctl,
    input  wire logic          req_valid,
    input  wire hpq_pkg::req_t req,
    input  wire logic          rsp_ready,
    output logic               rsp_valid,
    output hpq_pkg::rsp_t      rsp,
    output hpq_pkg::flags_t    flags
);

    localparam logic [hpq_pkg::CNT_W-1:0] CAP = hpq_pkg::CNT_W'(hpq_pkg::CAPACITY);

    logic signed [hpq_pkg::DATA_W-1:0] mem [hpq_pkg::CAPACITY];

    logic [hpq_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [hpq_pkg::CNT_W-1:0]         pos_reg, pos_next;
    logic signed [hpq_pkg::DATA_W-1:0] cur_reg;
    logic                              act_reg;
    hpq_pkg::status_t                  status_reg;
    logic signed [hpq_pkg::DATA_W-1:0] removed_reg;
    logic signed [hpq_pkg::DATA_W-1:0] rda_reg, rdb_reg;
    logic                              out_valid_reg;
    hpq_pkg::rsp_t                     out_reg;

    logic [hpq_pkg::IDX_W-1:0]         left_idx, right_idx, child_idx, wr_idx;
    logic [hpq_pkg::ADDR_W-1:0]        ra, rb, wa;
    logic signed [hpq_pkg::DATA_W-1:0] wd, child_val;
    logic                              wr_en, rd_en, l_gt, r_valid, pick_r, fail;

    // flags depend on state and the req_valid and rsp_ready inputs, never on the control word
    always_comb
    begin
        left_idx  = {pos_reg, 1'b0};
        right_idx = {pos_reg, 1'b1};
        wr_idx    = hpq_pkg::IDX_W'(pos_reg);
        r_valid   = right_idx <= hpq_pkg::IDX_W'(cnt_reg);
        l_gt      = rda_reg > cur_reg;
        // left wins ties; right only if strictly above the current best
        pick_r    = r_valid && (l_gt ? (rdb_reg > rda_reg) : (rdb_reg > cur_reg));
        child_idx = pick_r ? right_idx : left_idx;
        child_val = pick_r ? rdb_reg : rda_reg;
        fail      = act_reg ? (cnt_reg == '0) : (cnt_reg == CAP);

        flags.accept    = req_valid;
        flags.fail      = fail;
        flags.remove    = act_reg;
        flags.at_root   = (pos_reg == hpq_pkg::CNT_W'(1));
        flags.parent_ge = !(rda_reg < cur_reg);
        flags.no_left   = left_idx > hpq_pkg::IDX_W'(cnt_reg);
        flags.stay      = !(l_gt || pick_r);
        flags.out_busy  = out_valid_reg && !rsp_ready;
    end

    always_comb
    begin
        rd_en = 1'b1;
        ra    = hpq_pkg::addr_of(hpq_pkg::IDX_W'(1));
        rb    = hpq_pkg::addr_of(right_idx);
        unique case (ctl.rd)
            hpq_pkg::RD_NONE:      rd_en = 1'b0;
            hpq_pkg::RD_PARENT:    ra = hpq_pkg::addr_of(hpq_pkg::IDX_W'(pos_reg >> 1));
            hpq_pkg::RD_ROOT_LAST: rb = hpq_pkg::addr_of(hpq_pkg::IDX_W'(cnt_reg));
            hpq_pkg::RD_CHILDREN:  ra = hpq_pkg::addr_of(left_idx);
            hpq_pkg::RD_ROOT:      ra = hpq_pkg::addr_of(hpq_pkg::IDX_W'(1));
            default:               rd_en = 1'b0;
        endcase

        wa    = hpq_pkg::addr_of(wr_idx);
        wr_en = 1'b1;
        wd    = cur_reg;
        unique case (ctl.wr)
            hpq_pkg::WR_NONE:   wr_en = 1'b0;
            hpq_pkg::WR_CUR:    wd = cur_reg;
            hpq_pkg::WR_PARENT: wd = rda_reg;
            hpq_pkg::WR_CHILD:  wd = child_val;
            default:            wr_en = 1'b0;
        endcase

        unique case (ctl.pos)
            hpq_pkg::POS_HOLD:   pos_next = pos_reg;
            hpq_pkg::POS_NEW:    pos_next = cnt_reg + hpq_pkg::CNT_W'(1);
            hpq_pkg::POS_ONE:    pos_next = hpq_pkg::CNT_W'(1);
            hpq_pkg::POS_PARENT: pos_next = pos_reg >> 1;
            hpq_pkg::POS_CHILD:  pos_next = child_idx[hpq_pkg::CNT_W-1:0];
            default:             pos_next = pos_reg;
        endcase

        unique case (ctl.cnt)
            hpq_pkg::CNT_HOLD: cnt_next = cnt_reg;
            hpq_pkg::CNT_INC:  cnt_next = cnt_reg + hpq_pkg::CNT_W'(1);
            hpq_pkg::CNT_DEC:  cnt_next = cnt_reg - hpq_pkg::CNT_W'(1);
            default:           cnt_next = cnt_reg;
        endcase
    end

    // heap store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rda_reg <= mem[ra];
            rdb_reg <= mem[rb];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (ctl.take && flags.accept)
        begin
            act_reg     <= req.action;
            cur_reg     <= req.value;
            removed_reg <= '0;
        end
        if (ctl.judge)
        begin
            if (!fail)
            begin
                status_reg <= hpq_pkg::STAT_DONE;
            end
            else if (act_reg)
            begin
                status_reg <= hpq_pkg::STAT_EMPTY;
            end
            else
            begin
                status_reg <= hpq_pkg::STAT_FULL;
            end
        end
        if (ctl.load_rem)
        begin
            removed_reg <= rda_reg;
            cur_reg     <= rdb_reg;
        end
        if (ctl.emit)
        begin
            out_reg.status        <= status_reg;
            out_reg.removed_value <= removed_reg;
            out_reg.top_value     <= (cnt_reg != '0) ? rda_reg : '0;
            out_reg.entry_count   <= hpq_pkg::ENTRY_W'(cnt_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `HPQ_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= CAP)
    `HPQ_ASSERT_IMP(a_wr_in_heap, wr_en && cnt_reg != '0, pos_reg != '0 && pos_reg <= cnt_reg)
    `HPQ_ASSERT_NXT(a_emit_valid, ctl.emit, out_valid_reg && rsp.entry_count == hpq_pkg::ENTRY_W'($past(cnt_reg)))
    `HPQ_ASSERT_IMP(a_empty_top, out_valid_reg && rsp.entry_count == '0, rsp.top_value == '0)

endmodule

`default_nettype wire

// File: sv/max_heap_priority_queue_top.sv
// Binary max-heap priority queue of up to 64 signed 32-bit entries. Each req
// item inserts a value (action 0) or removes the maximum (action 1); each item
// gives exactly one rsp item with the status, the removed value, the new top and
// the entry count. A short microprogram walks the heap one level at a time: each
// level is one store read step followed by one compare-and-move step on the
// single store write port. An accepted insert or remove passes the dispatch and
// route steps before the walk and the place, top read and emit steps after it; a
// rejected one goes from dispatch straight to the top read and emit steps. One
// item is worked on at a time. The result register lets the next item be taken
// while a result waits; a result still waiting when the next one is ready holds
// the sequencer in its last step. The store needs no clearing after reset.
`default_nettype none

module max_heap_priority_queue_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire hpq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output hpq_pkg::rsp_t      rsp
);

    hpq_pkg::ctl_t   ctl;
    hpq_pkg::flags_t flags;
    logic            idle;

    hpq_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl),
        .idle  (idle)
    );

    hpq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req_valid (req_valid),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .flags     (flags)
    );

    assign req_ready = idle;

endmodule

`default_nettype wire
